// ----- hw/rtl/zslc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zslc_pkg: shared types and constants
// Config register indexes, queue token and limit structs, byte constants.
// ----------------------------------------------------------------------------
package zslc_pkg;

    localparam int STRIP_W      = 10;
    localparam int IN_TDATA_W   = 16;
    localparam int CH_LEN_W     = 12;
    localparam int POS_W        = 4;
    localparam int UNIT_LEN_W   = 16;
    localparam int OUT_TDATA_W  = 40;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int SPA_W        = 9;
    localparam int APC_W        = 3;
    localparam int CNT_W        = 5;
    localparam int STRIP_POS_W  = 10;
    localparam int APV_POS_W    = 8;
    localparam int SPC_W        = 11;

    // queue depth, power of two
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

    localparam logic [CH_LEN_W-1:0] HEADER_BYTES  = 12'd7;
    localparam logic [CH_LEN_W-1:0] CLUSTER_BYTES = 12'd2;

    localparam logic [SPA_W-1:0] SPA_MAX   = 9'd256;
    localparam logic [APC_W-1:0] APC_MAX   = 3'd4;
    localparam logic [CNT_W-1:0] CNT_MAX   = 5'd16;

    localparam logic [SPA_W-1:0] SPA_RST   = 9'd128;
    localparam logic [APC_W-1:0] APC_RST   = 3'd2;
    localparam logic [CNT_W-1:0] CPU_RST   = 5'd12;
    localparam logic [CNT_W-1:0] UPE_RST   = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIPS_PER_APV    = 2'd0,
        CFG_APVS_PER_CHANNEL  = 2'd1,
        CFG_CHANNELS_PER_UNIT = 2'd2,
        CFG_UNITS_PER_EVENT   = 2'd3
    } cfg_idx_t;

    // one classified strip
    typedef struct packed {
        logic nonzero;
        logic apv_end;
        logic chan_end;
    } strip_tok_t;

    // clamped unit/event limits for the back end
    typedef struct packed {
        logic [CNT_W-1:0] channels_per_unit;
        logic [CNT_W-1:0] units_per_event;
    } unit_lim_t;

endpackage

// ----- hw/rtl/zslc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zslc_front: config registers and strip classifier
// Tracks strip position in channel and APV, tags each item with its
// nonzero, APV end and channel end flags and pushes it into the queue.
// ----------------------------------------------------------------------------
module zslc_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [zslc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [zslc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [zslc_pkg::STRIP_W-1:0]      strip_value,
    input  logic                              q_full,
    output logic                              q_push,
    output zslc_pkg::strip_tok_t              q_tok,
    output zslc_pkg::unit_lim_t               lim
);
    import zslc_pkg::*;

    logic [SPA_W-1:0]       spa_reg;
    logic [APC_W-1:0]       apc_reg;
    logic [CNT_W-1:0]       cpu_reg;
    logic [CNT_W-1:0]       upe_reg;
    logic [STRIP_POS_W-1:0] strip_pos_reg, strip_pos_next;
    logic [APV_POS_W-1:0]   apv_pos_reg, apv_pos_next;

    logic [SPA_W-1:0]       spa;
    logic [APC_W-1:0]       apc;
    logic [SPA_W+APC_W-1:0] spc_full;
    logic [SPC_W-1:0]       spc;
    logic                   chan_end;
    logic                   apv_end;
    logic                   accept;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (v > CNT_MAX)
            r = CNT_MAX;
        else
            r = v;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spa_reg <= SPA_RST;
            apc_reg <= APC_RST;
            cpu_reg <= CPU_RST;
            upe_reg <= UPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STRIPS_PER_APV:    spa_reg <= cfg_data;
                CFG_APVS_PER_CHANNEL:  apc_reg <= cfg_data[APC_W-1:0];
                CFG_CHANNELS_PER_UNIT: cpu_reg <= cfg_data[CNT_W-1:0];
                CFG_UNITS_PER_EVENT:   upe_reg <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (spa_reg == '0)
            spa = SPA_W'(1);
        else if (spa_reg > SPA_MAX)
            spa = SPA_MAX;
        else
            spa = spa_reg;

        if (apc_reg == '0)
            apc = APC_W'(1);
        else if (apc_reg > APC_MAX)
            apc = APC_MAX;
        else
            apc = apc_reg;

        // at most 256 * 4 = 1024, fits the strip limit
        spc_full = spa * {{SPA_W{1'b0}}, apc};
        spc      = spc_full[SPC_W-1:0];
    end

    assign lim.channels_per_unit = clamp_cnt(cpu_reg);
    assign lim.units_per_event   = clamp_cnt(upe_reg);

    assign chan_end = ({1'b0, strip_pos_reg} + SPC_W'(1)) >= spc;
    assign apv_end  = ({1'b0, apv_pos_reg} + SPA_W'(1)) >= spa;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign q_push           = accept;
    assign q_tok.nonzero    = (strip_value != '0);
    assign q_tok.apv_end    = apv_end;
    assign q_tok.chan_end   = chan_end;

    always_comb
    begin
        strip_pos_next = strip_pos_reg;
        apv_pos_next   = apv_pos_reg;
        if (accept)
        begin
            if (chan_end)
            begin
                strip_pos_next = '0;
                apv_pos_next   = '0;
            end
            else
            begin
                strip_pos_next = strip_pos_reg + STRIP_POS_W'(1);
                apv_pos_next   = apv_end ? '0 : apv_pos_reg + APV_POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_pos_reg <= '0;
            apv_pos_reg   <= '0;
        end
        else
        begin
            strip_pos_reg <= strip_pos_next;
            apv_pos_reg   <= apv_pos_next;
        end
    end

endmodule

// ----- hw/rtl/zslc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zslc_fifo: short token queue
// Register queue between classifier and accumulator; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module zslc_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  zslc_pkg::strip_tok_t  push_tok,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output zslc_pkg::strip_tok_t  head_tok
);
    import zslc_pkg::*;

    strip_tok_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_tok  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_PTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/zslc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zslc_back: byte accumulator and result register
// Pops classified strips, counts cluster and header bytes, tracks channel
// and unit positions and holds each channel result until it is taken.
// ----------------------------------------------------------------------------
module zslc_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  zslc_pkg::unit_lim_t                lim,
    input  logic                               q_not_empty,
    input  zslc_pkg::strip_tok_t               q_tok,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [zslc_pkg::CH_LEN_W-1:0]      channel_length,
    output logic [zslc_pkg::POS_W-1:0]         channel_index,
    output logic [zslc_pkg::POS_W-1:0]         unit_index,
    output logic                               unit_done,
    output logic [zslc_pkg::UNIT_LEN_W-1:0]    unit_length,
    output logic                               event_done
);
    import zslc_pkg::*;

    logic                  open_reg, open_next;
    logic [CH_LEN_W-1:0]   ch_bytes_reg, ch_bytes_next;
    logic [UNIT_LEN_W-1:0] unit_bytes_reg, unit_bytes_next;
    logic [POS_W-1:0]      ch_pos_reg, ch_pos_next;
    logic [POS_W-1:0]      unit_pos_reg, unit_pos_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CH_LEN_W-1:0]   out_ch_len_reg;
    logic [POS_W-1:0]      out_ch_idx_reg;
    logic [POS_W-1:0]      out_unit_idx_reg;
    logic                  out_unit_done_reg;
    logic [UNIT_LEN_W-1:0] out_unit_len_reg;
    logic                  out_event_done_reg;

    logic                  out_free;
    logic                  open1;
    logic                  close_cl;
    logic [CH_LEN_W-1:0]   cb1, cb2, cb3;
    logic [UNIT_LEN_W-1:0] ub_sum;
    logic                  unit_end;
    logic                  event_end;
    logic                  emit;

    assign out_free = !out_valid_reg || out_ready;
    // strips that end no channel drain even while a result waits
    assign q_pop    = q_not_empty && (!q_tok.chan_end || out_free);
    assign emit     = q_pop && q_tok.chan_end;

    always_comb
    begin
        cb1      = q_tok.nonzero ? ch_bytes_reg + CH_LEN_W'(1) : ch_bytes_reg;
        open1    = open_reg || q_tok.nonzero;
        close_cl = open1 && (!q_tok.nonzero || q_tok.chan_end || q_tok.apv_end);
        cb2      = close_cl ? cb1 + CLUSTER_BYTES : cb1;
        cb3      = cb2 + HEADER_BYTES;
        ub_sum   = unit_bytes_reg + {{(UNIT_LEN_W-CH_LEN_W){1'b0}}, cb3};
        unit_end  = ({1'b0, ch_pos_reg} + CNT_W'(1)) >= lim.channels_per_unit;
        event_end = unit_end && (({1'b0, unit_pos_reg} + CNT_W'(1)) >= lim.units_per_event);
    end

    always_comb
    begin
        open_next       = open_reg;
        ch_bytes_next   = ch_bytes_reg;
        unit_bytes_next = unit_bytes_reg;
        ch_pos_next     = ch_pos_reg;
        unit_pos_next   = unit_pos_reg;
        if (q_pop)
        begin
            if (!q_tok.chan_end)
            begin
                open_next     = open1 && !close_cl;
                ch_bytes_next = cb2;
            end
            else
            begin
                open_next     = 1'b0;
                ch_bytes_next = '0;
                if (unit_end)
                begin
                    ch_pos_next     = '0;
                    unit_bytes_next = '0;
                    unit_pos_next   = event_end ? '0 : unit_pos_reg + POS_W'(1);
                end
                else
                begin
                    ch_pos_next     = ch_pos_reg + POS_W'(1);
                    unit_bytes_next = ub_sum;
                end
            end
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            ch_bytes_reg   <= '0;
            unit_bytes_reg <= '0;
            ch_pos_reg     <= '0;
            unit_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            open_reg       <= open_next;
            ch_bytes_reg   <= ch_bytes_next;
            unit_bytes_reg <= unit_bytes_next;
            ch_pos_reg     <= ch_pos_next;
            unit_pos_reg   <= unit_pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_ch_len_reg     <= cb3;
            out_ch_idx_reg     <= ch_pos_reg;
            out_unit_idx_reg   <= unit_pos_reg;
            out_unit_done_reg  <= unit_end;
            out_unit_len_reg   <= ub_sum;
            out_event_done_reg <= event_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_length = out_ch_len_reg;
    assign channel_index  = out_ch_idx_reg;
    assign unit_index     = out_unit_idx_reg;
    assign unit_done      = out_unit_done_reg;
    assign unit_length    = out_unit_len_reg;
    assign event_done     = out_event_done_reg;

endmodule

// ----- hw/rtl/zero_suppressed_length_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_suppressed_length_counter: per-channel zero-suppressed byte lengths
//
// Strip samples enter on s_axis in readout order (strips of a channel,
// channels of a unit, units of an event), one item per cycle at full rate.
// On the last strip of each channel one result leaves on m_axis: the
// channel length with headers, its channel and unit index, the running
// unit total, tlast on the last channel of a unit and tuser on the last
// channel of the event. Other strips produce no result.
// A channel's last strip is written to the token queue when accepted
// and moved into the result register when the back end pops it.
// Throughput: one strip per cycle, set by the accumulator step in the
// back end, unless a channel-end strip waits on a stalled result.
// Geometry is set through cfg_we/cfg_index/cfg_data while idle.
// Reset clears all positions and counts and loads the default geometry
// (128 strips per APV, 2 APVs, 12 channels, 8 units).
// If m_axis stalls, the result register holds; the back end keeps draining
// strips that end no channel, and once the 4-entry queue fills,
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module zero_suppressed_length_counter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [zslc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [zslc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] strip_value, [15:10] zero
    input  logic [zslc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [11:0] channel_length, [15:12] channel_index, [19:16] unit_index,
    // [35:20] unit_length, [39:36] zero
    output logic [zslc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // unit_done
    output logic                                 m_axis_tlast,
    // [0] event_done
    output logic                                 m_axis_tuser
);
    import zslc_pkg::*;

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_not_empty;
    strip_tok_t            push_tok;
    strip_tok_t            head_tok;
    unit_lim_t             lim;
    logic [CH_LEN_W-1:0]   channel_length;
    logic [POS_W-1:0]      channel_index;
    logic [POS_W-1:0]      unit_index;
    logic [UNIT_LEN_W-1:0] unit_length;

    zslc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .strip_value (s_axis_tdata[STRIP_W-1:0]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_tok       (push_tok),
        .lim         (lim)
    );

    zslc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_tok  (push_tok),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_tok  (head_tok)
    );

    zslc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .lim            (lim),
        .q_not_empty    (q_not_empty),
        .q_tok          (head_tok),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .channel_length (channel_length),
        .channel_index  (channel_index),
        .unit_index     (unit_index),
        .unit_done      (m_axis_tlast),
        .unit_length    (unit_length),
        .event_done     (m_axis_tuser)
    );

    assign m_axis_tdata = {
        {(OUT_TDATA_W-CH_LEN_W-2*POS_W-UNIT_LEN_W){1'b0}},
        unit_length,
        unit_index,
        channel_index,
        channel_length
    };

endmodule

// ----- hw/rtl/zslc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zslc_checker: port-level checks
// Watches the result stream of the length counter; bound to the top level.
// ----------------------------------------------------------------------------
module zslc_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [zslc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic                              m_axis_tuser
);
    import zslc_pkg::*;

    // end of event is always end of a unit
    a_event_is_unit_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("event end without unit end");

    // every channel carries at least its header bytes
    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:0] >= HEADER_BYTES)
        else $error("channel length below header size");

    // running unit total includes the current channel
    a_unit_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[35:20] >= {4'b0, m_axis_tdata[11:0]})
        else $error("unit total below channel length");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind zero_suppressed_length_counter zslc_checker u_zslc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/tb_zero_suppressed_length_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zero_suppressed_length_counter: self-checking bench for the ZS length counter
// Streams strip samples under a series of geometries (small, clamped, extreme,
// shrunk mid-channel), predicts every channel length and unit total, and
// compares each result item field by field. Both sides idle at random; one
// phase holds the result side off long enough to back the input up.
// ----------------------------------------------------------------------------
module tb_zero_suppressed_length_counter;
    import zslc_pkg::*;

    localparam int CYCLE_LIMIT        = 200000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int LONG_HOLD          = 120;
    localparam int RANDOM_ITEMS       = 550;
    localparam int MAX_CHANNEL_STRIPS = 1024;
    localparam int MAX_PRINTED        = 200;

    typedef struct packed {
        logic [CH_LEN_W-1:0]   ch_len;
        logic [POS_W-1:0]      ch_idx;
        logic [POS_W-1:0]      unit_idx;
        logic                  unit_done;
        logic [UNIT_LEN_W-1:0] unit_len;
        logic                  event_done;
    } chan_len_t;

    typedef struct packed {
        logic [STRIP_W-1:0] value;
        logic               typed;
        chan_len_t          want;
    } strip_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] spa;
        logic [CFG_DATA_W-1:0] apc;
        logic [CFG_DATA_W-1:0] cpu;
        logic [CFG_DATA_W-1:0] upe;
        logic [15:0]           items;
        logic                  long_hold;
    } geometry_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;

    // predictor copy of the geometry registers and the counting state
    logic [SPA_W-1:0]        reg_spa;
    logic [APC_W-1:0]        reg_apc;
    logic [CNT_W-1:0]        reg_cpu;
    logic [CNT_W-1:0]        reg_upe;
    logic                    cl_open;
    logic [STRIP_POS_W-1:0]  strip_pos;
    logic [APV_POS_W-1:0]    apv_pos;
    logic [POS_W-1:0]        chan_pos;
    logic [POS_W-1:0]        unit_pos;
    logic [CH_LEN_W-1:0]     chan_bytes;
    logic [UNIT_LEN_W-1:0]   unit_bytes;

    chan_len_t pending_lengths [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        random_strips = 0;
    bit        tx_idle;
    bit        rx_idle;
    int        rx_hold;

    // Directed run at 2 strips/APV, 2 APVs, 2 channels, 2 units: 4 strips per
    // channel, APV boundary after the second strip, event ends every 16 strips.
    strip_row_t dir_rows [24] = '{
        // unit 0, channel 0: all zero, header only
        '{10'd0,    1'b0, '0},
        '{10'd0,    1'b0, '0},
        '{10'd0,    1'b0, '0},
        '{10'd0,    1'b1, {12'd7, 4'd0, 4'd0, 1'b0, 16'd7, 1'b0}},
        // unit 0, channel 1: full scale, cluster split at the APV boundary
        '{10'd1023, 1'b0, '0},
        '{10'd1023, 1'b0, '0},
        '{10'd1023, 1'b0, '0},
        '{10'd1023, 1'b1, {12'd15, 4'd1, 4'd0, 1'b1, 16'd22, 1'b0}},
        // unit 1, channel 0: clusters closed by zero strips
        '{10'd5,    1'b0, '0},
        '{10'd0,    1'b0, '0},
        '{10'd5,    1'b0, '0},
        '{10'd0,    1'b1, {12'd13, 4'd0, 4'd1, 1'b0, 16'd13, 1'b0}},
        // unit 1, channel 1: last channel of the event
        '{10'd0,    1'b0, '0},
        '{10'd1,    1'b0, '0},
        '{10'd2,    1'b0, '0},
        '{10'd0,    1'b1, {12'd13, 4'd1, 4'd1, 1'b1, 16'd26, 1'b1}},
        // positions wrap, new event
        '{10'd1,    1'b0, '0},
        '{10'd1,    1'b0, '0},
        '{10'd1,    1'b0, '0},
        '{10'd1,    1'b1, {12'd15, 4'd0, 4'd0, 1'b0, 16'd15, 1'b0}},
        // cluster closed by the channel end
        '{10'd0,    1'b0, '0},
        '{10'd0,    1'b0, '0},
        '{10'd0,    1'b0, '0},
        '{10'h200,  1'b1, {12'd10, 4'd1, 4'd0, 1'b1, 16'd25, 1'b0}}
    };

    geometry_row_t geometry_rows [7] = '{
        '{9'd1,   9'd1, 9'd1,  9'd1,  16'd30,  1'b1},  // a result per strip, sink held off
        '{9'd0,   9'd0, 9'd0,  9'd0,  16'd20,  1'b0},  // zero registers act as one
        '{9'd3,   9'd7, 9'd31, 9'd31, 16'd50,  1'b0},  // over-range counts clamp
        '{9'd511, 9'd1, 9'd1,  9'd1,  16'd30,  1'b0},  // leaves a channel part done
        '{9'd2,   9'd1, 9'd1,  9'd1,  16'd10,  1'b0},  // position already past limit
        '{9'd256, 9'd1, 9'd16, 9'd16, 16'd260, 1'b0},  // widest APV
        '{9'd1,   9'd4, 9'd16, 9'd2,  16'd30,  1'b0}
    };

    zero_suppressed_length_counter i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int clamp_limit(input int v, input int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // advances the counting state by one strip; returns 1 when a channel ends
    function automatic bit predict_channel_length(input logic [STRIP_W-1:0] v,
                                                  output chan_len_t r);
        int spa;
        int spc;
        int cpu;
        int upe;
        bit chan_end;
        bit apv_end;
        bit unit_end;
        spa = clamp_limit(int'(reg_spa), 256);
        spc = spa * clamp_limit(int'(reg_apc), 4);
        if (spc > MAX_CHANNEL_STRIPS)
            spc = MAX_CHANNEL_STRIPS;
        cpu = clamp_limit(int'(reg_cpu), 16);
        upe = clamp_limit(int'(reg_upe), 16);
        chan_end = (int'(strip_pos) + 1) >= spc;
        apv_end  = (int'(apv_pos) + 1) >= spa;
        r = '0;

        if (v != '0)
        begin
            cl_open = 1'b1;
            chan_bytes = chan_bytes + 1'b1;
        end
        if (cl_open && (v == '0 || chan_end || apv_end))
        begin
            chan_bytes = chan_bytes + CLUSTER_BYTES;
            cl_open = 1'b0;
        end
        if (!chan_end)
        begin
            strip_pos = strip_pos + 1'b1;
            apv_pos = apv_end ? '0 : apv_pos + 1'b1;
            return 1'b0;
        end

        chan_bytes = chan_bytes + HEADER_BYTES;
        unit_bytes = unit_bytes + UNIT_LEN_W'(chan_bytes);
        unit_end = (int'(chan_pos) + 1) >= cpu;
        r.ch_len     = chan_bytes;
        r.ch_idx     = chan_pos;
        r.unit_idx   = unit_pos;
        r.unit_done  = unit_end;
        r.unit_len   = unit_bytes;
        r.event_done = unit_end && ((int'(unit_pos) + 1) >= upe);

        strip_pos  = '0;
        apv_pos    = '0;
        cl_open    = 1'b0;
        chan_bytes = '0;
        if (unit_end)
        begin
            chan_pos   = '0;
            unit_bytes = '0;
            unit_pos   = r.event_done ? '0 : unit_pos + 1'b1;
        end
        else
            chan_pos = chan_pos + 1'b1;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // appends one expected result at the tail of the pending list
    task automatic queue_expected(input chan_len_t r);
        pending_lengths.insert(pending_lengths.size(), r);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_STRIPS_PER_APV:    reg_spa = val[SPA_W-1:0];
            CFG_APVS_PER_CHANNEL:  reg_apc = val[APC_W-1:0];
            CFG_CHANNELS_PER_UNIT: reg_cpu = val[CNT_W-1:0];
            CFG_UNITS_PER_EVENT:   reg_upe = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input geometry_row_t g);
        write_reg(CFG_STRIPS_PER_APV, g.spa);
        write_reg(CFG_APVS_PER_CHANNEL, g.apc);
        write_reg(CFG_CHANNELS_PER_UNIT, g.cpu);
        write_reg(CFG_UNITS_PER_EVENT, g.upe);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_strip(input logic [STRIP_W-1:0] v, input logic typed,
                              input chan_len_t want);
        int        gap;
        chan_len_t got;
        bit        produced;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(v);
        do
            @(posedge clk);
        while (!s_axis_tready);
        produced = predict_channel_length(v, got);
        if (typed)
            queue_expected(want);
        else if (produced)
            queue_expected(got);
    endtask

    // stop sending, let every result come out and the strip queue drain
    task automatic settle_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_lengths.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input geometry_row_t g);
        int                 pick;
        logic [STRIP_W-1:0] v;
        set_geometry(g);
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
        if (g.long_hold)
        begin
            rx_hold = LONG_HOLD;
            tx_idle = 1'b0;
        end
        repeat (g.items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                v = '0;
            else if (pick == 5)
                v = '1;
            else
                v = STRIP_W'($urandom_range(1, 1023));
            send_strip(v, 1'b0, '0);
        end
        random_strips += g.items;
        settle_idle();
    endtask

    initial
    begin : result_sink
        int        gap;
        chan_len_t want;
        @(posedge rst_n);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (rx_hold > 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (pending_lengths.size() == 0)
                flag_mismatch("unexpected result, channel_length", m_axis_tdata[11:0], 0);
            else
            begin
                want = pending_lengths.pop_front();
                if (m_axis_tdata[11:0] !== want.ch_len)
                    flag_mismatch("channel_length", m_axis_tdata[11:0], want.ch_len);
                if (m_axis_tdata[15:12] !== want.ch_idx)
                    flag_mismatch("channel_index", m_axis_tdata[15:12], want.ch_idx);
                if (m_axis_tdata[19:16] !== want.unit_idx)
                    flag_mismatch("unit_index", m_axis_tdata[19:16], want.unit_idx);
                if (m_axis_tdata[35:20] !== want.unit_len)
                    flag_mismatch("unit_length", m_axis_tdata[35:20], want.unit_len);
                if (m_axis_tlast !== want.unit_done)
                    flag_mismatch("unit_done", m_axis_tlast, want.unit_done);
                if (m_axis_tuser !== want.event_done)
                    flag_mismatch("event_done", m_axis_tuser, want.event_done);
            end
        end
    end

    initial
    begin : stimulus
        geometry_row_t g;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_STRIPS_PER_APV;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold       = 0;
        reg_spa       = SPA_RST;
        reg_apc       = APC_RST;
        reg_cpu       = CPU_RST;
        reg_upe       = UPE_RST;
        cl_open       = 1'b0;
        strip_pos     = '0;
        apv_pos       = '0;
        chan_pos      = '0;
        unit_pos      = '0;
        chan_bytes    = '0;
        unit_bytes    = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_geometry('{9'd2, 9'd2, 9'd2, 9'd2, 16'd24, 1'b0});
        foreach (dir_rows[i])
            send_strip(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        settle_idle();

        foreach (geometry_rows[i])
            run_phase(geometry_rows[i]);

        // random geometries, short channels so results stay frequent
        while (random_strips < RANDOM_ITEMS)
        begin
            g.spa       = CFG_DATA_W'($urandom_range(0, 6));
            g.apc       = CFG_DATA_W'($urandom_range(0, 511));
            g.cpu       = CFG_DATA_W'($urandom_range(0, 511));
            g.upe       = CFG_DATA_W'($urandom_range(0, 511));
            g.items     = 16'($urandom_range(10, 40));
            g.long_hold = 1'b0;
            run_phase(g);
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
